@@ rtl/core/b64d_pkg.sv @@
`timescale 1ns / 1ps

package b64d_pkg;

    // Character codes with a meaning of their own
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Group buffer and output widths
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned GROUP_W  = 18;
    localparam int unsigned WORD_W   = 24;
    localparam int unsigned BYTE_W   = 8;

    // Number of sextets already held in the group buffer
    typedef enum logic [1:0] {
        CNT_NONE  = 2'd0,
        CNT_ONE   = 2'd1,
        CNT_TWO   = 2'd2,
        CNT_THREE = 2'd3
    } sextet_cnt_t;

    // Number of bytes that one decoded group yields
    typedef enum logic [1:0] {
        NB_ONE   = 2'd1,
        NB_TWO   = 2'd2,
        NB_THREE = 2'd3
    } nbytes_t;

    // One decoded group as it travels from the front part to the back part
    typedef struct packed {
        logic [WORD_W-1:0] word;    // bytes from the top down
        nbytes_t           nbytes;  // how many bytes of word are used
        logic              last;    // the group ends the message
    } group_t;

endpackage

@@ rtl/core/b64d_front.sv @@
`timescale 1ns / 1ps

module b64d_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        symbol,
    input  logic              final_symbol,
    output logic              push,
    output b64d_pkg::group_t  push_group,
    input  logic              queue_full
);
    import b64d_pkg::*;

    logic [GROUP_W-1:0]  group_bits_reg;
    logic [GROUP_W-1:0]  group_bits_next;
    sextet_cnt_t         sextet_count_reg;
    sextet_cnt_t         sextet_count_next;
    logic                third_was_pad_reg;
    logic                third_was_pad_next;
    logic [SEXTET_W-1:0] sextet;
    logic                pad;
    logic                accept;
    logic [WORD_W-1:0]   word;
    nbytes_t             nbytes;

    // Map one character to its sextet; unknown codes give zero
    function automatic logic [SEXTET_W-1:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                v = c - 8'h41;
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                v = c - 8'h61 + 8'd26;
            end
            else if (c >= 8'h30 && c <= 8'h39)
            begin
                v = c - 8'h30 + 8'd52;
            end
            else if (c == 8'h2B || c == 8'h2D || c == 8'h2E)
            begin
                v = 8'd62;
            end
            else if (c == 8'h2C || c == 8'h2F || c == 8'h5F)
            begin
                v = 8'd63;
            end
            return v[SEXTET_W-1:0];
        end
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign sextet   = sextet_of(symbol);
    assign pad      = (symbol == PAD_CHAR);

    // Align the gathered sextets and the new one, in arrival order, at the top of the word
    always_comb
    begin
        word   = '0;
        nbytes = NB_ONE;
        unique case (sextet_count_reg)
            CNT_NONE:
            begin
                word = {sextet, 18'd0};
            end
            CNT_ONE:
            begin
                word = {group_bits_reg[5:0], sextet, 12'd0};
            end
            CNT_TWO:
            begin
                word   = {group_bits_reg[11:0], sextet, 6'd0};
                nbytes = pad ? NB_ONE : NB_TWO;
            end
            CNT_THREE:
            begin
                word = {group_bits_reg, sextet};
                if (!final_symbol || !pad)
                begin
                    nbytes = NB_THREE;
                end
                else if (!third_was_pad_reg)
                begin
                    nbytes = NB_TWO;
                end
                else
                begin
                    nbytes = NB_ONE;
                end
            end
            default:
            begin
                word = '0;
            end
        endcase
    end

    // Emit a group on a full quartet or on the last character
    assign push              = accept && (final_symbol || sextet_count_reg == CNT_THREE);
    assign push_group.word   = word;
    assign push_group.nbytes = nbytes;
    assign push_group.last   = final_symbol;

    // Gather sextets, clear after a group is emitted
    always_comb
    begin
        group_bits_next    = group_bits_reg;
        sextet_count_next  = sextet_count_reg;
        third_was_pad_next = third_was_pad_reg;
        if (push)
        begin
            group_bits_next    = '0;
            sextet_count_next  = CNT_NONE;
            third_was_pad_next = 1'b0;
        end
        else if (accept)
        begin
            group_bits_next   = {group_bits_reg[GROUP_W-SEXTET_W-1:0], sextet};
            sextet_count_next = sextet_cnt_t'(sextet_count_reg + 2'd1);
            if (sextet_count_reg == CNT_TWO)
            begin
                third_was_pad_next = pad;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg    <= '0;
            sextet_count_reg  <= CNT_NONE;
            third_was_pad_reg <= 1'b0;
        end
        else
        begin
            group_bits_reg    <= group_bits_next;
            sextet_count_reg  <= sextet_count_next;
            third_was_pad_reg <= third_was_pad_next;
        end
    end

endmodule

@@ rtl/core/b64d_queue.sv @@
`timescale 1ns / 1ps

module b64d_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64d_pkg::group_t  push_group,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output b64d_pkg::group_t  head_group
);
    import b64d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    group_t           entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_group = entries[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed group
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_group;
        end
    end

endmodule

@@ rtl/core/b64d_back.sv @@
`timescale 1ns / 1ps

module b64d_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  b64d_pkg::group_t  head_group,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        data_byte,
    output logic              message_end
);
    import b64d_pkg::*;

    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] data_byte_reg;
    logic              message_end_reg;
    logic [BYTE_W-1:0] sel_byte;
    logic              entry_done;
    logic              load;

    // Load a new byte when the output register is empty or being taken
    assign load       = head_valid && (!out_valid_reg || out_ready);
    assign entry_done = (idx_reg == 2'(head_group.nbytes - 2'd1));
    assign pop        = load && entry_done;

    // Pick the byte of the head group, top byte first
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = head_group.word[23:16];
            2'd1:    sel_byte = head_group.word[15:8];
            2'd2:    sel_byte = head_group.word[7:0];
            default: sel_byte = '0;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = entry_done ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output byte until it is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_byte_reg   <= sel_byte;
            message_end_reg <= head_group.last && entry_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = data_byte_reg;
    assign message_end = message_end_reg;

endmodule

@@ rtl/core/base64_stream_decoder.sv @@
`timescale 1ns / 1ps

// Base64 stream decoder. One character per input item arrives on s_tdata,
// with s_tlast on the last character of a message; decoded bytes leave one
// per item on m_tdata, with m_tlast on the last byte of the message. The
// alphabet is lenient: '+' '-' '.' decode to 62, ',' '/' '_' to 63, and any
// other unknown code, '=' included, decodes to 0 without error. A final group
// yields one to three bytes depending on '=' padding; a lone final character
// yields one byte. A character is taken every cycle while the group queue
// (QUEUE_DEPTH entries) has room; while m_tready is held high the output
// side gives one byte per cycle, so three bytes per four characters keep up
// with the input indefinitely. The last character of a group completes a queue
// entry, from which its first byte is then loaded into the output register.
module base64_stream_decoder
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // final_symbol
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic       m_tlast    // message_end
);
    import b64d_pkg::*;

    logic   push;
    group_t push_group;
    logic   queue_full;
    logic   pop;
    logic   head_valid;
    group_t head_group;

    // Accept characters and build groups
    b64d_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .symbol       (s_tdata),
        .final_symbol (s_tlast),
        .push         (push),
        .push_group   (push_group),
        .queue_full   (queue_full)
    );

    // Buffer decoded groups between the two sides
    b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_group (head_group)
    );

    // Serialize groups into bytes
    b64d_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_group  (head_group),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .data_byte   (m_tdata),
        .message_end (m_tlast)
    );

endmodule

@@ sim/base64_stream_decoder_checker.sv @@
`timescale 1ns / 1ps

module base64_stream_decoder_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // final_symbol
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] data_byte
    input  logic       m_tlast,   // message_end
    output int         fail_count,
    output int         outstanding
);
    import b64d_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              ends;
    } decoded_byte_t;

    // Decoder state as the prediction tracks it
    logic [GROUP_W-1:0] gathered_bits;
    sextet_cnt_t        gathered_cnt;
    logic               third_pad;

    decoded_byte_t      expected_bytes[$];
    decoded_byte_t      head;

    function automatic logic [SEXTET_W-1:0] sextet_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return 6'(c - "A");
        end
        if (c >= "a" && c <= "z")
        begin
            return 6'(c - "a" + 26);
        end
        if (c >= "0" && c <= "9")
        begin
            return 6'(c - "0" + 52);
        end
        if (c == "+" || c == "-" || c == ".")
        begin
            return 6'd62;
        end
        if (c == "," || c == "/" || c == "_")
        begin
            return 6'd63;
        end
        // Anything else, pad included, counts as zero
        return 6'd0;
    endfunction

    function automatic void queue_byte(input logic [7:0] value, input logic ends);
        decoded_byte_t item;
        item.value = value;
        item.ends  = ends;
        expected_bytes.push_back(item);
    endfunction

    function automatic void clear_group();
        gathered_bits = '0;
        gathered_cnt  = CNT_NONE;
        third_pad     = 1'b0;
    endfunction

    // Advance the group by one character and queue the bytes it releases
    function automatic void decode_symbol(input logic [7:0] c, input logic fin);
        logic [SEXTET_W-1:0] s;
        logic [WORD_W-1:0]   word;
        logic                pad;
        s   = sextet_value(c);
        pad = (c == PAD_CHAR);
        if (!fin)
        begin
            if (gathered_cnt != CNT_THREE)
            begin
                gathered_bits = {gathered_bits[11:0], s};
                if (gathered_cnt == CNT_TWO)
                begin
                    third_pad = pad;
                end
                gathered_cnt = sextet_cnt_t'(gathered_cnt + 2'd1);
            end
            else
            begin
                word = {gathered_bits, s};
                queue_byte(word[23:16], 1'b0);
                queue_byte(word[15:8], 1'b0);
                queue_byte(word[7:0], 1'b0);
                clear_group();
            end
            return;
        end

        // Final character: one to three bytes depending on padding
        case (gathered_cnt)
            CNT_THREE:
            begin
                word = {gathered_bits, s};
                if (!pad)
                begin
                    queue_byte(word[23:16], 1'b0);
                    queue_byte(word[15:8], 1'b0);
                    queue_byte(word[7:0], 1'b1);
                end
                else if (!third_pad)
                begin
                    queue_byte(word[23:16], 1'b0);
                    queue_byte(word[15:8], 1'b1);
                end
                else
                begin
                    queue_byte(word[23:16], 1'b1);
                end
            end
            CNT_TWO:
            begin
                word = {gathered_bits[11:0], s, 6'd0};
                if (!pad)
                begin
                    queue_byte(word[23:16], 1'b0);
                    queue_byte(word[15:8], 1'b1);
                end
                else
                begin
                    queue_byte(word[23:16], 1'b1);
                end
            end
            CNT_ONE:
            begin
                word = {gathered_bits[5:0], s, 12'd0};
                queue_byte(word[23:16], 1'b1);
            end
            default:
            begin
                // Lone character: missing sextet taken as zero
                queue_byte({s, 2'b00}, 1'b1);
            end
        endcase
        clear_group();
    endfunction

    // Compare each output item, then predict from each input item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_group();
            expected_bytes.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected output item: data_byte %0h message_end %0b",
                           m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    head = expected_bytes.pop_front();
                    if (m_tdata !== head.value)
                    begin
                        $error("data_byte mismatch: expected %0h, actual %0h",
                               head.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== head.ends)
                    begin
                        $error("message_end mismatch: expected %0b, actual %0b",
                               head.ends, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_symbol(s_tdata, s_tlast);
            end
            outstanding = expected_bytes.size();
        end
    end

endmodule

@@ sim/base64_stream_decoder_tb.sv @@
`timescale 1ns / 1ps

module base64_stream_decoder_tb;
    import b64d_pkg::*;

    localparam int SYMBOL_TARGET = 360;
    localparam int LONG_HOLD     = 60;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] symbol
    logic       s_tlast;   // final_symbol
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] data_byte
    logic       m_tlast;   // message_end

    int    fail_count;
    int    outstanding;
    int    symbols_sent = 0;
    bit    tx_calm = 1'b0;
    bit    rx_calm = 1'b0;
    bit    rx_hold_request = 1'b0;
    string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-.,_";

    base64_stream_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    base64_stream_decoder_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [7:0] pick_symbol();
        return b64_chars[$urandom_range(0, b64_chars.len() - 1)];
    endfunction

    // Offer one character after a random gap and hold it until taken
    task automatic send_symbol(input logic [7:0] c, input logic fin);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        symbols_sent++;
    endtask

    task automatic send_text(input string txt, input bit ends);
        int i;
        for (i = 0; i < txt.len(); i++)
        begin
            send_symbol(txt[i], ends && (i == txt.len() - 1));
        end
    endtask

    // Stop offering and wait for every predicted byte to come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    // Receiver: random or long hold-off before each output item
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                rx_calm = !rx_calm;
            end
            if (rx_hold_request)
            begin
                gap = LONG_HOLD;
                rx_hold_request = 1'b0;
            end
            else
            begin
                gap = rx_calm ? 0 : $urandom_range(0, 9);
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Sender: directed messages, then random messages, then the verdict
    initial
    begin
        logic [7:0] msg[$];
        int         kind;
        int         groups;
        int         len;
        int         i;
        bit         hold_done;
        bit         pause_done;

        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Pad inside a full group, the lenient 62 and 63 characters, then padded and short final groups
        send_text("TW=u", 1'b0);
        send_text("-.,_", 1'b1);
        send_text("TQ==", 1'b1);
        send_text("TWE=", 1'b1);
        send_text("TWE", 1'b1);
        send_text("TQ=", 1'b1);
        // Code extremes in a final group of two
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b1);
        // Lone final character
        send_text("/", 1'b1);
        drain_results();

        while (symbols_sent < SYMBOL_TARGET)
        begin
            msg.delete();
            tx_calm = ($urandom_range(0, 4) == 0);
            if (!hold_done && symbols_sent >= 120)
            begin
                // Hold the output long while characters keep coming
                rx_hold_request = 1'b1;
                tx_calm   = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && symbols_sent >= 250)
            begin
                drain_results();
                pause_done = 1'b1;
            end

            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                // Well-formed message with random content and padding form
                groups = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8)
                                                     : $urandom_range(0, 3);
                repeat (groups * 4) msg.push_back(pick_symbol());
                case ($urandom_range(0, 4))
                    0:
                    begin
                        repeat (4) msg.push_back(pick_symbol());
                    end
                    1:
                    begin
                        repeat (2) msg.push_back(pick_symbol());
                        msg.push_back(PAD_CHAR);
                        msg.push_back(PAD_CHAR);
                    end
                    2:
                    begin
                        repeat (3) msg.push_back(pick_symbol());
                        msg.push_back(PAD_CHAR);
                    end
                    default:
                    begin
                        len = $urandom_range(1, 3);
                        repeat (len) msg.push_back(pick_symbol());
                    end
                endcase
                // Break one character of some messages
                if (kind == 7)
                begin
                    i = $urandom_range(0, msg.size() - 1);
                    msg[i] = $urandom_range(0, 1) ? PAD_CHAR : 8'($urandom_range(0, 255));
                end
            end
            else
            begin
                // Noise: any byte codes at all
                len = $urandom_range(1, 10);
                repeat (len) msg.push_back(8'($urandom_range(0, 255)));
            end

            for (i = 0; i < msg.size(); i++)
            begin
                send_symbol(msg[i], i == msg.size() - 1);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
